// ===== rtl/core/ffps_pkg.sv =====
`default_nettype none

package ffps_pkg;

    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int IDX_W      = 10;
    localparam int LEN_W      = 11;
    localparam int WIN_W      = 12;
    localparam int RBIN_W     = 11;
    localparam int PHASE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int LEN_CAP    = (1 << LEN_W) - 1;
    localparam int BIN_LIMIT  = 1023;

    localparam int CORDIC_STEPS = 22;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int ZW           = 26;
    localparam int CORDIC_PRE   = 16;
    localparam int CORDIC_HEAD  = 3;
    localparam int QUARTER      = 1 << 22;
    localparam int PHASE_SHIFT  = 8;
    localparam int PHASE_ROUND  = 1 << (PHASE_SHIFT - 1);

    localparam int QUEUE_DEPTH  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 3'd0,
        CFG_NUM_COLS = 3'd1,
        CFG_RATE_LO  = 3'd2,
        CFG_RATE_HI  = 3'd3,
        CFG_DELAY_LO = 3'd4,
        CFG_DELAY_HI = 3'd5,
        CFG_NEGATE   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0]        num_rows;
        logic [LEN_W-1:0]        num_cols;
        logic signed [WIN_W-1:0] rate_lo;
        logic signed [WIN_W-1:0] rate_hi;
        logic signed [WIN_W-1:0] delay_lo;
        logic signed [WIN_W-1:0] delay_hi;
        logic                    negate;
    } t_cfg;

    function automatic logic [LEN_W-1:0] cap_len(input logic [LEN_W-1:0] n, input int maxv);
        int cap;
        cap = (maxv > LEN_CAP) ? LEN_CAP : maxv;
        return (n > LEN_W'(cap)) ? LEN_W'(cap) : n;
    endfunction

    // atan(2^-i) in units of pi/2^23
    function automatic logic signed [ZW-1:0] atan_val(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:    v = ZW'(2097152);
            5'd1:    v = ZW'(1238021);
            5'd2:    v = ZW'(654136);
            5'd3:    v = ZW'(332050);
            5'd4:    v = ZW'(166669);
            5'd5:    v = ZW'(83416);
            5'd6:    v = ZW'(41718);
            5'd7:    v = ZW'(20860);
            5'd8:    v = ZW'(10430);
            5'd9:    v = ZW'(5215);
            5'd10:   v = ZW'(2608);
            5'd11:   v = ZW'(1304);
            5'd12:   v = ZW'(652);
            5'd13:   v = ZW'(326);
            5'd14:   v = ZW'(163);
            5'd15:   v = ZW'(81);
            5'd16:   v = ZW'(41);
            5'd17:   v = ZW'(20);
            5'd18:   v = ZW'(10);
            5'd19:   v = ZW'(5);
            5'd20:   v = ZW'(3);
            5'd21:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ffps_bin_if.sv =====
`default_nettype none

interface ffps_bin_if
    import ffps_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] bin_re;
    logic signed [SAMPLE_BITS-1:0] bin_im;
    logic [IDX_W-1:0]              row;
    logic [IDX_W-1:0]              col;
    logic                          last;

    modport source (output valid, bin_re, bin_im, row, col, last, input ready);
    modport sink   (input valid, bin_re, bin_im, row, col, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffps_peak_if.sv =====
`default_nettype none

interface ffps_peak_if
    import ffps_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic [IDX_W-1:0]              peak_row;
    logic [IDX_W-1:0]              peak_col;
    logic signed [RBIN_W-1:0]      rate_bin;
    logic signed [RBIN_W-1:0]      delay_bin;
    logic [2*SAMPLE_BITS-1:0]      peak_power;
    logic signed [PHASE_W-1:0]     peak_phase;
    logic                          found;

    modport source (output valid, peak_row, peak_col, rate_bin, delay_bin, peak_power,
                    peak_phase, found, input ready);
    modport sink   (input valid, peak_row, peak_col, rate_bin, delay_bin, peak_power,
                    peak_phase, found, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffps_queue.sv =====
`default_nettype none

module ffps_queue
    import ffps_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [WIDTH-1:0]               i_data,
    input  wire logic                           i_pop,
    output logic [WIDTH-1:0]                    o_data,
    output logic                                o_empty,
    output logic [$clog2(DEPTH+1)-1:0]          o_count
);
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count != CNT_W'(DEPTH)))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("frame queue underflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("frame queue count mismatch");

endmodule

`default_nettype wire

// ===== rtl/core/ffps_front.sv =====
`default_nettype none

module ffps_front
    import ffps_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int REC_W       = 1 + 2*IDX_W + 4*SAMPLE_BITS,
    parameter int DEPTH       = QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ffps_bin_if.sink                        i_bin,
    input  wire t_cfg                       i_cfg,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_q_count,
    output logic                            o_push,
    output logic [REC_W-1:0]                o_rec
);
    localparam int PW    = 2 * SAMPLE_BITS;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic win_ok(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] len,
                                    input logic signed [WIN_W-1:0] lo_in,
                                    input logic signed [WIN_W-1:0] hi_in);
        logic signed [WIN_W:0] lo;
        logic signed [WIN_W:0] hi;
        logic signed [WIN_W:0] v;
        logic signed [WIN_W:0] w;
        lo = (lo_in > hi_in) ? {hi_in[WIN_W-1], hi_in} : {lo_in[WIN_W-1], lo_in};
        hi = (lo_in > hi_in) ? {lo_in[WIN_W-1], lo_in} : {hi_in[WIN_W-1], hi_in};
        if (lo == hi) begin
            hi = lo + (WIN_W+1)'(1);
        end
        v = {3'b000, idx};
        w = v - {2'b00, len};
        return (idx != '0) && ({1'b0, idx} < len) &&
               ((v >= lo && v < hi) || (w < 0 && w >= lo && w < hi));
    endfunction

    logic [LEN_W-1:0]        nr;
    logic [LEN_W-1:0]        nc;
    logic                    acc;
    logic [CNT_W:0]          pend;
    logic signed [PW-1:0]    sq_re;
    logic signed [PW-1:0]    sq_im;

    logic                    r_s1_valid;
    logic                    r_s1_last;
    logic                    r_s1_qual;
    logic                    r_s1_origin;
    logic [IDX_W-1:0]        r_s1_row;
    logic [IDX_W-1:0]        r_s1_col;
    logic [SAMPLE_BITS-1:0]  r_s1_re;
    logic [SAMPLE_BITS-1:0]  r_s1_im;
    logic [PW-1:0]           r_s1_sq_re;
    logic [PW-1:0]           r_s1_sq_im;

    logic                    r_have;
    logic [PW-1:0]           r_best_pw;
    logic [IDX_W-1:0]        r_best_row;
    logic [IDX_W-1:0]        r_best_col;
    logic [SAMPLE_BITS-1:0]  r_best_re;
    logic [SAMPLE_BITS-1:0]  r_best_im;
    logic [PW-1:0]           r_org_pw;
    logic [SAMPLE_BITS-1:0]  r_org_re;
    logic [SAMPLE_BITS-1:0]  r_org_im;

    logic [PW-1:0]           pw;
    logic                    take;
    logic                    n_have;
    logic [PW-1:0]           n_best_pw;
    logic [IDX_W-1:0]        n_best_row;
    logic [IDX_W-1:0]        n_best_col;
    logic [SAMPLE_BITS-1:0]  n_best_re;
    logic [SAMPLE_BITS-1:0]  n_best_im;
    logic [PW-1:0]           n_org_pw;
    logic [SAMPLE_BITS-1:0]  n_org_re;
    logic [SAMPLE_BITS-1:0]  n_org_im;

    assign nr = cap_len(i_cfg.num_rows, MAX_ROWS);
    assign nc = cap_len(i_cfg.num_cols, MAX_COLS);

    // room for every frame end already in flight
    assign pend        = {1'b0, i_q_count} + (CNT_W+1)'(r_s1_valid && r_s1_last);
    assign i_bin.ready = (pend < (CNT_W+1)'(DEPTH));
    assign acc         = i_bin.valid && i_bin.ready;

    assign sq_re = i_bin.bin_re * i_bin.bin_re;
    assign sq_im = i_bin.bin_im * i_bin.bin_im;

    assign pw   = r_s1_sq_re + r_s1_sq_im;
    assign take = r_s1_valid && r_s1_qual && (!r_have || pw > r_best_pw);

    always_comb begin
        n_have     = r_have || take;
        n_best_pw  = take ? pw : r_best_pw;
        n_best_row = take ? r_s1_row : r_best_row;
        n_best_col = take ? r_s1_col : r_best_col;
        n_best_re  = take ? r_s1_re : r_best_re;
        n_best_im  = take ? r_s1_im : r_best_im;
        n_org_pw   = (r_s1_valid && r_s1_origin) ? pw : r_org_pw;
        n_org_re   = (r_s1_valid && r_s1_origin) ? r_s1_re : r_org_re;
        n_org_im   = (r_s1_valid && r_s1_origin) ? r_s1_im : r_org_im;
    end

    assign o_push = r_s1_valid && r_s1_last;
    assign o_rec  = n_have ? {1'b1, n_best_row, n_best_col, n_best_pw, n_best_re, n_best_im}
                           : {1'b0, IDX_W'(0), IDX_W'(0), n_org_pw, n_org_re, n_org_im};

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_last   <= i_bin.last;
            r_s1_qual   <= win_ok(i_bin.row, nr, i_cfg.rate_lo, i_cfg.rate_hi) &&
                           win_ok(i_bin.col, nc, i_cfg.delay_lo, i_cfg.delay_hi);
            r_s1_origin <= (i_bin.row == '0) && (i_bin.col == '0);
            r_s1_row    <= i_bin.row;
            r_s1_col    <= i_bin.col;
            r_s1_re     <= i_bin.bin_re;
            r_s1_im     <= i_bin.bin_im;
            r_s1_sq_re  <= sq_re;
            r_s1_sq_im  <= sq_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_have     <= 1'b0;
            r_best_pw  <= '0;
            r_best_row <= '0;
            r_best_col <= '0;
            r_best_re  <= '0;
            r_best_im  <= '0;
            r_org_pw   <= '0;
            r_org_re   <= '0;
            r_org_im   <= '0;
        end else begin
            r_s1_valid <= acc;
            if (o_push) begin
                r_have     <= 1'b0;
                r_best_pw  <= '0;
                r_best_row <= '0;
                r_best_col <= '0;
                r_best_re  <= '0;
                r_best_im  <= '0;
                r_org_pw   <= '0;
                r_org_re   <= '0;
                r_org_im   <= '0;
            end else begin
                r_have     <= n_have;
                r_best_pw  <= n_best_pw;
                r_best_row <= n_best_row;
                r_best_col <= n_best_col;
                r_best_re  <= n_best_re;
                r_best_im  <= n_best_im;
                r_org_pw   <= n_org_pw;
                r_org_re   <= n_org_re;
                r_org_im   <= n_org_im;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ffps_back.sv =====
`default_nettype none

module ffps_back
    import ffps_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int REC_W       = 1 + 2*IDX_W + 4*SAMPLE_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [REC_W-1:0] i_rec,
    input  wire logic             i_empty,
    output logic                  o_pop,
    input  wire t_cfg             i_cfg,
    ffps_peak_if.source           o_peak
);
    localparam int PW = 2 * SAMPLE_BITS;
    localparam int CW = SAMPLE_BITS + CORDIC_PRE + CORDIC_HEAD;
    localparam int PH_W = ZW - PHASE_SHIFT + 1;

    localparam int IM_LSB  = 0;
    localparam int RE_LSB  = SAMPLE_BITS;
    localparam int PW_LSB  = 2 * SAMPLE_BITS;
    localparam int COL_LSB = PW_LSB + PW;
    localparam int ROW_LSB = COL_LSB + IDX_W;
    localparam int FND_BIT = ROW_LSB + IDX_W;

    typedef enum logic [1:0] {S_IDLE, S_ROT, S_DONE} t_state;

    function automatic logic [RBIN_W-1:0] sbin(input logic [IDX_W-1:0] idx,
                                               input logic [LEN_W-1:0] len, input logic neg);
        logic signed [LEN_W+1:0] v;
        v = {3'b000, idx};
        if ({idx, 1'b0} > len) begin
            v = v - {2'b00, len};
        end
        if (neg) begin
            v = -v;
        end
        if (v > (LEN_W+2)'(BIN_LIMIT)) begin
            v = (LEN_W+2)'(BIN_LIMIT);
        end else if (v < -(LEN_W+2)'(BIN_LIMIT)) begin
            v = -(LEN_W+2)'(BIN_LIMIT);
        end
        return v[RBIN_W-1:0];
    endfunction

    t_state                    r_state;
    logic [STEP_W-1:0]         r_step;
    logic signed [CW-1:0]      r_x;
    logic signed [CW-1:0]      r_y;
    logic signed [ZW-1:0]      r_z;
    logic                      r_zero;
    logic                      r_found;
    logic [IDX_W-1:0]          r_row;
    logic [IDX_W-1:0]          r_col;
    logic [PW-1:0]             r_pw;

    logic                      r_out_valid;
    logic [IDX_W-1:0]          r_out_row;
    logic [IDX_W-1:0]          r_out_col;
    logic [RBIN_W-1:0]         r_out_rate;
    logic [RBIN_W-1:0]         r_out_delay;
    logic [PW-1:0]             r_out_pw;
    logic [PHASE_W-1:0]        r_out_phase;
    logic                      r_out_found;

    logic signed [SAMPLE_BITS-1:0] rec_re;
    logic signed [SAMPLE_BITS-1:0] rec_im;
    logic signed [CW-1:0]      xe;
    logic signed [CW-1:0]      ye;
    logic signed [CW-1:0]      x0;
    logic signed [CW-1:0]      y0;
    logic signed [ZW-1:0]      z0;
    logic signed [CW-1:0]      dx;
    logic signed [CW-1:0]      dy;
    logic signed [ZW-1:0]      zr;
    logic signed [PH_W-1:0]    ph;
    logic signed [PH_W-1:0]    phn;
    logic [PHASE_W-1:0]        phase;
    logic                      load_out;

    assign rec_re = i_rec[RE_LSB +: SAMPLE_BITS];
    assign rec_im = i_rec[IM_LSB +: SAMPLE_BITS];
    assign xe = {{(CW-SAMPLE_BITS){rec_re[SAMPLE_BITS-1]}}, rec_re} <<< CORDIC_PRE;
    assign ye = {{(CW-SAMPLE_BITS){rec_im[SAMPLE_BITS-1]}}, rec_im} <<< CORDIC_PRE;

    always_comb begin
        if (rec_re[SAMPLE_BITS-1]) begin
            if (!rec_im[SAMPLE_BITS-1]) begin
                x0 = ye;
                y0 = -xe;
                z0 = ZW'(QUARTER);
            end else begin
                x0 = -ye;
                y0 = xe;
                z0 = -ZW'(QUARTER);
            end
        end else begin
            x0 = xe;
            y0 = ye;
            z0 = '0;
        end
    end

    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;

    assign zr  = r_z + ZW'(PHASE_ROUND);
    assign ph  = PH_W'(zr >>> PHASE_SHIFT);
    assign phn = i_cfg.negate ? -ph : ph;

    always_comb begin
        if (r_zero) begin
            phase = '0;
        end else if (phn > PH_W'((1 << (PHASE_W-1)) - 1)) begin
            phase = PHASE_W'((1 << (PHASE_W-1)) - 1);
        end else if (phn < -PH_W'(1 << (PHASE_W-1))) begin
            phase = PHASE_W'(1 << (PHASE_W-1));
        end else begin
            phase = phn[PHASE_W-1:0];
        end
    end

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_peak.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_peak.valid && o_peak.ready && !load_out) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_x     <= x0;
                        r_y     <= y0;
                        r_z     <= z0;
                        r_zero  <= (rec_re == '0) && (rec_im == '0);
                        r_found <= i_rec[FND_BIT];
                        r_row   <= i_rec[ROW_LSB +: IDX_W];
                        r_col   <= i_rec[COL_LSB +: IDX_W];
                        r_pw    <= i_rec[PW_LSB +: PW];
                        r_step  <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (!r_y[CW-1]) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + atan_val(r_step);
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - atan_val(r_step);
                    end
                    if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= r_row;
                        r_out_col   <= r_col;
                        r_out_rate  <= sbin(r_row, cap_len(i_cfg.num_rows, MAX_ROWS),
                                            i_cfg.negate);
                        r_out_delay <= sbin(r_col, cap_len(i_cfg.num_cols, MAX_COLS),
                                            i_cfg.negate);
                        r_out_pw    <= r_pw;
                        r_out_phase <= phase;
                        r_out_found <= r_found;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_peak.valid      = r_out_valid;
    assign o_peak.peak_row   = r_out_row;
    assign o_peak.peak_col   = r_out_col;
    assign o_peak.rate_bin   = r_out_rate;
    assign o_peak.delay_bin  = r_out_delay;
    assign o_peak.peak_power = r_out_pw;
    assign o_peak.peak_phase = r_out_phase;
    assign o_peak.found      = r_out_found;

endmodule

`default_nettype wire

// ===== rtl/core/fringe_fft_peak_search.sv =====
// Throughput: one bin per cycle while the frame queue has room; the back end runs one
//   frame at a time through the shared 22-step CORDIC and pops the next only when done.
// A result passes from the last bin of a frame through the power/compare stage, the
//   queue hop, the 22 CORDIC steps and the output load before it is valid.
// A 4-entry frame queue decouples the compare pipeline from the CORDIC.
// Reset (synchronous, active low) clears the frame state and loads default config.
`default_nettype none

module fringe_fft_peak_search
    import ffps_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ffps_bin_if.sink                   i_bin,
    ffps_peak_if.source                o_peak
);
    localparam int REC_W = 1 + 2*IDX_W + 4*SAMPLE_BITS;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg               r_cfg;
    logic               q_push;
    logic [REC_W-1:0]   q_in;
    logic               q_pop;
    logic [REC_W-1:0]   q_out;
    logic               q_empty;
    logic [CNT_W-1:0]   q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_rows <= LEN_W'(1024);
            r_cfg.num_cols <= LEN_W'(1024);
            r_cfg.rate_lo  <= -WIN_W'(512);
            r_cfg.rate_hi  <= WIN_W'(512);
            r_cfg.delay_lo <= -WIN_W'(512);
            r_cfg.delay_hi <= WIN_W'(512);
            r_cfg.negate   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_ROWS: r_cfg.num_rows <= i_cfg_data[LEN_W-1:0];
                CFG_NUM_COLS: r_cfg.num_cols <= i_cfg_data[LEN_W-1:0];
                CFG_RATE_LO:  r_cfg.rate_lo  <= i_cfg_data;
                CFG_RATE_HI:  r_cfg.rate_hi  <= i_cfg_data;
                CFG_DELAY_LO: r_cfg.delay_lo <= i_cfg_data;
                CFG_DELAY_HI: r_cfg.delay_hi <= i_cfg_data;
                CFG_NEGATE:   r_cfg.negate   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ffps_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .REC_W       (REC_W),
        .DEPTH       (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bin     (i_bin),
        .i_cfg     (r_cfg),
        .i_q_count (q_count),
        .o_push    (q_push),
        .o_rec     (q_in)
    );

    ffps_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    ffps_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .REC_W       (REC_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (q_out),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_cfg   (r_cfg),
        .o_peak  (o_peak)
    );

endmodule

`default_nettype wire

// ===== bench/tb_fringe_fft_peak_search.sv =====
module tb_fringe_fft_peak_search;
    import ffps_pkg::*;

    localparam int SB = DEF_SAMPLE_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 32;

    typedef struct packed {
        logic signed [SB-1:0] re;
        logic signed [SB-1:0] im;
        logic [IDX_W-1:0]     row;
        logic [IDX_W-1:0]     col;
        logic                 last;
    } bin_t;

    typedef struct packed {
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [RBIN_W-1:0]  rate;
        logic signed [RBIN_W-1:0]  delay;
        logic [2*SB-1:0]           power;
        logic signed [PHASE_W-1:0] phase;
        logic                      found;
    } peak_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ffps_bin_if  bin_ch ();
    ffps_peak_if peak_ch ();

    fringe_fft_peak_search uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_bin      (bin_ch),
        .o_peak     (peak_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_cfg   cfg_shadow;
    longint best_pwr, best_re, best_im, org_re, org_im;
    int     best_row, best_col;
    bit     have_best;

    bin_t  bin_q[$];
    peak_t peak_q[$];
    int    bins_pending;
    int    errors;

    bit bin_taken, peak_taken;
    int bin_gap, peak_gap;
    int bin_mode, peak_mode;

    function automatic longint atan_step(int i);
        case (i)
            0:  return 2097152;
            1:  return 1238021;
            2:  return 654136;
            3:  return 332050;
            4:  return 166669;
            5:  return 83416;
            6:  return 41718;
            7:  return 20860;
            8:  return 10430;
            9:  return 5215;
            10: return 2608;
            11: return 1304;
            12: return 652;
            13: return 326;
            14: return 163;
            15: return 81;
            16: return 41;
            17: return 20;
            18: return 10;
            19: return 5;
            20: return 3;
            21: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [PHASE_W-1:0] cordic_phase(longint re, longint im, bit neg);
        longint x, y, z, nx, ny;
        if (re == 0 && im == 0) return '0;
        x = re * (64'sd1 <<< CORDIC_PRE);
        y = im * (64'sd1 <<< CORDIC_PRE);
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; ny = -x; z = QUARTER;
            end else begin
                nx = -y; ny = x; z = -QUARTER;
            end
            x = nx;
            y = ny;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
            end
            x = nx;
            y = ny;
        end
        z = (z + PHASE_ROUND) >>> PHASE_SHIFT;
        if (neg) z = -z;
        if (z > 32767) z = 32767;
        if (z < -32768) z = -32768;
        return PHASE_W'(z);
    endfunction

    function automatic bit bin_in_window(int idx, int len, int lo, int hi);
        int t;
        if (lo > hi) begin
            t = lo; lo = hi; hi = t;
        end
        if (lo == hi) hi = lo + 1;
        if (idx <= 0 || idx >= len) return 1'b0;
        if (idx >= lo && idx < hi) return 1'b1;
        t = idx - len;
        return t < 0 && t >= lo && t < hi;
    endfunction

    function automatic logic signed [RBIN_W-1:0] wrapped_bin(int idx, int len, bit neg);
        int v;
        v = idx;
        if (2 * v > len) v -= len;
        if (neg) v = -v;
        if (v > BIN_LIMIT) v = BIN_LIMIT;
        if (v < -BIN_LIMIT) v = -BIN_LIMIT;
        return RBIN_W'(v);
    endfunction

    function automatic int axis_len(int n, int cap);
        return (n > cap) ? cap : n;
    endfunction

    function automatic void clear_frame();
        best_pwr = 0; best_re = 0; best_im = 0; org_re = 0; org_im = 0;
        best_row = 0; best_col = 0; have_best = 1'b0;
    endfunction

    function automatic void frame_accumulate(bin_t b);
        longint re, im, pw, pre, pim;
        int nr, nc, prow, pcol;
        peak_t res;
        re = b.re;
        im = b.im;
        nr = axis_len(cfg_shadow.num_rows, DEF_MAX_ROWS);
        nc = axis_len(cfg_shadow.num_cols, DEF_MAX_COLS);
        pw = re * re + im * im;
        if (b.row == 0 && b.col == 0) begin
            org_re = re;
            org_im = im;
        end
        if (bin_in_window(b.row, nr, cfg_shadow.rate_lo, cfg_shadow.rate_hi) &&
            bin_in_window(b.col, nc, cfg_shadow.delay_lo, cfg_shadow.delay_hi) &&
            (!have_best || pw > best_pwr)) begin
            have_best = 1'b1;
            best_pwr = pw;
            best_row = b.row;
            best_col = b.col;
            best_re = re;
            best_im = im;
        end
        if (!b.last) return;
        if (have_best) begin
            pre = best_re; pim = best_im; prow = best_row; pcol = best_col;
        end else begin
            pre = org_re; pim = org_im; prow = 0; pcol = 0;
        end
        res.row   = IDX_W'(prow);
        res.col   = IDX_W'(pcol);
        res.rate  = wrapped_bin(prow, nr, cfg_shadow.negate);
        res.delay = wrapped_bin(pcol, nc, cfg_shadow.negate);
        res.power = (2*SB)'(pre * pre + pim * pim);
        res.phase = cordic_phase(pre, pim, cfg_shadow.negate);
        res.found = have_best;
        peak_q.push_back(res);
        clear_frame();
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic int draw_gap(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 2);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    // request driver
    always @(negedge i_clk) begin
        bin_t nxt;
        if (bin_ch.valid && !bin_taken) begin
        end else if (bin_gap != 0) begin
            bin_gap <= bin_gap - 1;
            bin_ch.valid <= 1'b0;
        end else if (bin_q.size() != 0) begin
            nxt = bin_q.pop_front();
            bin_ch.bin_re <= nxt.re;
            bin_ch.bin_im <= nxt.im;
            bin_ch.row    <= nxt.row;
            bin_ch.col    <= nxt.col;
            bin_ch.last   <= nxt.last;
            bin_ch.valid  <= 1'b1;
            bin_gap <= draw_gap(bin_mode);
            if ($urandom_range(0, 39) == 0) bin_mode <= $urandom_range(0, 2);
        end else begin
            bin_ch.valid <= 1'b0;
        end
    end

    // result sink
    always @(negedge i_clk) begin
        int g;
        g = peak_gap;
        if (peak_taken) begin
            g = draw_gap(peak_mode);
            if ($urandom_range(0, 19) == 0) peak_mode <= $urandom_range(0, 2);
        end
        if (g != 0) begin
            peak_ch.ready <= 1'b0;
            peak_gap <= g - 1;
        end else begin
            peak_ch.ready <= 1'b1;
            peak_gap <= 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        peak_t want;
        bin_t  got_bin;
        bin_taken  <= i_rst_n && bin_ch.valid && bin_ch.ready;
        peak_taken <= i_rst_n && peak_ch.valid && peak_ch.ready;
        if (i_rst_n && peak_ch.valid && peak_ch.ready) begin
            if (peak_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result row %0d col %0d", $time,
                         peak_ch.peak_row, peak_ch.peak_col);
            end else begin
                want = peak_q.pop_front();
                check_field("peak_row", want.row, peak_ch.peak_row);
                check_field("peak_col", want.col, peak_ch.peak_col);
                check_field("rate_bin", want.rate, peak_ch.rate_bin);
                check_field("delay_bin", want.delay, peak_ch.delay_bin);
                check_field("peak_power", want.power, peak_ch.peak_power);
                check_field("peak_phase", want.phase, peak_ch.peak_phase);
                check_field("found", want.found, peak_ch.found);
            end
        end
        if (i_rst_n && bin_ch.valid && bin_ch.ready) begin
            got_bin.re   = bin_ch.bin_re;
            got_bin.im   = bin_ch.bin_im;
            got_bin.row  = bin_ch.row;
            got_bin.col  = bin_ch.col;
            got_bin.last = bin_ch.last;
            bins_pending--;
            frame_accumulate(got_bin);
        end
    end

    task automatic push_bin(logic signed [SB-1:0] re, logic signed [SB-1:0] im,
                            int row, int col, bit last);
        bin_t b;
        b.re = re;
        b.im = im;
        b.row = IDX_W'(row);
        b.col = IDX_W'(col);
        b.last = last;
        bin_q.push_back(b);
        bins_pending++;
    endtask

    task automatic settle();
        while (bins_pending != 0 || peak_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_NUM_ROWS: cfg_shadow.num_rows = data[LEN_W-1:0];
            CFG_NUM_COLS: cfg_shadow.num_cols = data[LEN_W-1:0];
            CFG_RATE_LO:  cfg_shadow.rate_lo  = data;
            CFG_RATE_HI:  cfg_shadow.rate_hi  = data;
            CFG_DELAY_LO: cfg_shadow.delay_lo = data;
            CFG_DELAY_HI: cfg_shadow.delay_hi = data;
            CFG_NEGATE:   cfg_shadow.negate   = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(t_cfg c);
        cfg_write(CFG_NUM_ROWS, CFG_DATA_W'(c.num_rows));
        cfg_write(CFG_NUM_COLS, CFG_DATA_W'(c.num_cols));
        cfg_write(CFG_RATE_LO, c.rate_lo);
        cfg_write(CFG_RATE_HI, c.rate_hi);
        cfg_write(CFG_DELAY_LO, c.delay_lo);
        cfg_write(CFG_DELAY_HI, c.delay_hi);
        cfg_write(CFG_NEGATE, CFG_DATA_W'(c.negate));
    endtask

    function automatic logic signed [SB-1:0] rand_sample();
        logic signed [SB-1:0] s;
        int w;
        w = $urandom_range(1, SB);
        s = SB'($urandom);
        case ($urandom_range(0, 11))
            0: s = {1'b0, {(SB-1){1'b1}}};
            1: s = {1'b1, {(SB-1){1'b0}}};
            2: s = '0;
            default: s = s >>> (SB - w);
        endcase
        return s;
    endfunction

    function automatic int axis_pick();
        case ($urandom_range(0, 5))
            0: return 2;
            1: return 1024;
            2: return $urandom_range(2, 1024);
            default: return $urandom_range(2, 48);
        endcase
    endfunction

    function automatic logic signed [WIN_W-1:0] rand_edge(int len);
        int span;
        span = ($urandom_range(0, 3) == 0) ? 1024 : len;
        return WIN_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.num_rows = LEN_W'(axis_pick());
        c.num_cols = LEN_W'(axis_pick());
        c.rate_lo  = rand_edge(c.num_rows);
        c.rate_hi  = ($urandom_range(0, 5) == 0) ? c.rate_lo : rand_edge(c.num_rows);
        c.delay_lo = rand_edge(c.num_cols);
        c.delay_hi = ($urandom_range(0, 5) == 0) ? c.delay_lo : rand_edge(c.num_cols);
        c.negate   = $urandom_range(0, 1);
        return c;
    endfunction

    // mostly a wrapped scan over a small patch; some frames are scattered noise
    task automatic gen_frame(output int count);
        int nr, nc, len, w, r0, c0, row, col;
        bit noisy;
        logic signed [SB-1:0] re, im;
        nr = axis_len(cfg_shadow.num_rows, DEF_MAX_ROWS);
        nc = axis_len(cfg_shadow.num_cols, DEF_MAX_COLS);
        len = $urandom_range(1, 24);
        w = $urandom_range(1, 8);
        r0 = $urandom_range(0, nr - 1);
        c0 = $urandom_range(0, nc - 1);
        noisy = ($urandom_range(0, 4) == 0);
        re = rand_sample();
        im = rand_sample();
        for (int k = 0; k < len; k++) begin
            if (noisy) begin
                row = $urandom_range(0, 1023);
                col = $urandom_range(0, 1023);
            end else if (k == 0 && $urandom_range(0, 1) == 1) begin
                row = 0;
                col = 0;
            end else begin
                row = (r0 + k / w) % nr;
                col = (c0 + k % w) % nc;
            end
            if ($urandom_range(0, 5) != 0) begin
                re = rand_sample();
                im = rand_sample();
            end
            push_bin(re, im, row, col, k == len - 1);
        end
        count = len;
    endtask

    initial begin
        t_cfg c;
        int phase_items, n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_NUM_ROWS;
        i_cfg_data = '0;
        bin_ch.valid = 1'b0;
        bin_ch.bin_re = '0;
        bin_ch.bin_im = '0;
        bin_ch.row = '0;
        bin_ch.col = '0;
        bin_ch.last = 1'b0;
        peak_ch.ready = 1'b0;
        errors = 0;
        bins_pending = 0;
        bin_mode = 2;
        peak_mode = 2;
        cfg_shadow.num_rows = 11'd1024;
        cfg_shadow.num_cols = 11'd1024;
        cfg_shadow.rate_lo  = -12'sd512;
        cfg_shadow.rate_hi  = 12'sd512;
        cfg_shadow.delay_lo = -12'sd512;
        cfg_shadow.delay_hi = 12'sd512;
        cfg_shadow.negate   = 1'b0;
        clear_frame();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // default windows: extremes, ties, wrap, zero row/col, empty frames
        push_bin(5, -7, 0, 0, 0);
        push_bin(24'sh7FFFFF, 24'sh800000, 3, 5, 0);
        push_bin(24'sh800000, 24'sh7FFFFF, 1023, 1023, 0);
        push_bin(0, 0, 600, 10, 0);
        push_bin(1000, -1000, 512, 3, 0);
        push_bin(24'sh7FFFFF, 24'sh7FFFFF, 0, 7, 1);
        push_bin(-100, 0, 0, 0, 0);
        push_bin(24'sh7FFFFF, 1, 9, 0, 1);
        push_bin(3, 4, 0, 0, 0);
        push_bin(24'sh800000, 0, 0, 0, 0);
        push_bin(77, 77, 2, 0, 1);
        push_bin(0, 0, 5, 1020, 1);
        push_bin(12345, -5, 0, 1, 1);
        push_bin(-1, 1, 700, 700, 0);
        push_bin(1, -1, 511, 511, 0);
        push_bin(0, 0, 513, 513, 1);
        settle();

        // smallest axes, swapped and degenerate windows, negation
        c.num_rows = 11'd2;
        c.num_cols = 11'd2;
        c.rate_lo  = 12'sd1024;
        c.rate_hi  = -12'sd1024;
        c.delay_lo = 12'sd1;
        c.delay_hi = 12'sd1;
        c.negate   = 1'b1;
        apply_cfg(c);
        cfg_write(CFG_UNUSED, '1);
        push_bin(100, 0, 1, 2, 0);
        push_bin(200, 0, 3, 1, 0);
        push_bin(24'sh800000, -1, 1, 1, 1);
        push_bin(24'sh800000, 0, 1, 1, 1);
        settle();

        for (int p = 0; p < 10; p++) begin
            if (p == 0) begin
                c.num_rows = 11'd1024;
                c.num_cols = 11'd1024;
                c.rate_lo  = -12'sd1024;
                c.rate_hi  = 12'sd1024;
                c.delay_lo = 12'sd1024;
                c.delay_hi = -12'sd1024;
                c.negate   = 1'b1;
            end else if (p == 1) begin
                c = random_cfg();
                c.num_rows = 11'd3;
                c.rate_lo  = -12'sd1;
                c.rate_hi  = -12'sd1;
                c.negate   = 1'b0;
            end else begin
                c = random_cfg();
            end
            apply_cfg(c);
            if (p == 5) cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
            phase_items = 0;
            while (phase_items < 95) begin
                gen_frame(n);
                phase_items += n;
            end
            settle();
        end

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
